FILE: hdl/pcfbc_pkg.sv
// shared types, constants and helper functions for the packet class flow byte counter
package pcfbc_pkg;

    localparam int TABLE_ENTRIES_DEF   = 128;
    localparam int BYTE_COUNT_BITS_DEF = 48;

    localparam int NUM_CLASSES = 7;
    localparam int CLASS_W     = 3;
    localparam int COUNT_W     = 32;
    localparam int SLOT_W      = 7;
    localparam int BYTES_OUT_W = 48;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_RARP = 16'h8035;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [7:0] TH_FIN  = 8'h01;
    localparam logic [7:0] TH_SYN  = 8'h02;
    localparam logic [7:0] TH_RST  = 8'h04;
    localparam logic [7:0] TH_PUSH = 8'h08;
    localparam logic [7:0] TH_ACK  = 8'h10;
    localparam logic [7:0] TH_URG  = 8'h20;

    typedef enum logic [CLASS_W-1:0] {
        CLS_ARP   = 3'd0,
        CLS_RARP  = 3'd1,
        CLS_ICMP  = 3'd2,
        CLS_IGMP  = 3'd3,
        CLS_TCP   = 3'd4,
        CLS_UDP   = 3'd5,
        CLS_OTHER = 3'd6
    } t_class;

    typedef enum logic [1:0] {
        FS_UNTRACKED = 2'd0,
        FS_UPDATED   = 2'd1,
        FS_INSERTED  = 2'd2,
        FS_FULL      = 2'd3
    } t_flow_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SEND
    } t_state;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic                    done;
        t_flow_status            status;
        logic [SLOT_W-1:0]       slot;
        logic [BYTES_OUT_W-1:0]  bytes;
        logic [31:0]             saddr;
        logic [31:0]             daddr;
        logic [15:0]             sport;
        logic [15:0]             dport;
        logic [15:0]             len;
    } t_token;

    function automatic t_class classify(input logic [15:0] etype, input logic [7:0] proto);
        t_class c;
        c = CLS_OTHER;
        if (etype == ETH_TYPE_IPV4) begin
            if (proto == PROTO_ICMP)      c = CLS_ICMP;
            else if (proto == PROTO_IGMP) c = CLS_IGMP;
            else if (proto == PROTO_TCP)  c = CLS_TCP;
            else if (proto == PROTO_UDP)  c = CLS_UDP;
        end else if (etype == ETH_TYPE_ARP) begin
            c = CLS_ARP;
        end else if (etype == ETH_TYPE_RARP) begin
            c = CLS_RARP;
        end
        return c;
    endfunction

    function automatic logic flags_tracked(input logic [7:0] f);
        return (f == TH_SYN) || (f == TH_ACK) || (f == TH_RST) ||
               (f == (TH_SYN | TH_ACK)) || (f == (TH_ACK | TH_PUSH)) ||
               (f == (TH_URG | TH_ACK)) || (f == (TH_FIN | TH_ACK)) ||
               (f == (TH_RST | TH_ACK));
    endfunction

endpackage

FILE: hdl/pcfbc_cell.sv
// one flow table slot: holds a key and byte total, matches or claims the passing token
module pcfbc_cell #(
    parameter int CELL_INDEX      = 0,
    parameter int BYTE_COUNT_BITS = pcfbc_pkg::BYTE_COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcfbc_pkg::t_token i_tok,
    output pcfbc_pkg::t_token o_tok
);
    import pcfbc_pkg::*;

    logic                       r_valid;
    logic [95:0]                r_key;
    logic [BYTE_COUNT_BITS-1:0] r_total;
    t_token                     r_tok;

    logic                       n_valid;
    logic [95:0]                n_key;
    logic [BYTE_COUNT_BITS-1:0] n_total;
    t_token                     n_tok;

    logic                       live;
    logic                       fwd;
    logic                       rev;
    logic                       hit;
    logic                       claim;
    logic [BYTE_COUNT_BITS:0]   sum;
    logic [BYTE_COUNT_BITS-1:0] upd_total;
    logic [63:0]                wide_total;

    // compare in both directions; valid slots form a prefix, so the first free one claims
    always_comb begin
        live  = i_tok.valid && !i_tok.done;
        fwd   = (r_key == {i_tok.saddr, i_tok.daddr, i_tok.sport, i_tok.dport});
        rev   = (r_key == {i_tok.daddr, i_tok.saddr, i_tok.dport, i_tok.sport});
        hit   = live && r_valid && (fwd || rev);
        claim = live && !r_valid;
        sum   = {1'b0, r_total} + (BYTE_COUNT_BITS + 1)'(i_tok.len);
        upd_total = sum[BYTE_COUNT_BITS] ? {BYTE_COUNT_BITS{1'b1}}
                                         : sum[BYTE_COUNT_BITS-1:0];
        n_valid = r_valid;
        n_key   = r_key;
        n_total = r_total;
        n_tok   = i_tok;
        wide_total = 64'(upd_total);
        if (hit) begin
            n_total      = upd_total;
            n_tok.done   = 1'b1;
            n_tok.status = FS_UPDATED;
            n_tok.slot   = SLOT_W'(CELL_INDEX);
            n_tok.bytes  = wide_total[BYTES_OUT_W-1:0];
        end else if (claim) begin
            wide_total   = 64'(i_tok.len);
            n_valid      = 1'b1;
            n_key        = {i_tok.saddr, i_tok.daddr, i_tok.sport, i_tok.dport};
            n_total      = BYTE_COUNT_BITS'(i_tok.len);
            n_tok.done   = 1'b1;
            n_tok.status = FS_INSERTED;
            n_tok.slot   = SLOT_W'(CELL_INDEX);
            n_tok.bytes  = wide_total[BYTES_OUT_W-1:0];
        end
    end

    // slot state and token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_tok.valid <= n_tok.valid;
        end
        r_key   <= n_key;
        r_total <= n_total;
        r_tok.done   <= n_tok.done;
        r_tok.status <= n_tok.status;
        r_tok.slot   <= n_tok.slot;
        r_tok.bytes  <= n_tok.bytes;
        r_tok.saddr  <= n_tok.saddr;
        r_tok.daddr  <= n_tok.daddr;
        r_tok.sport  <= n_tok.sport;
        r_tok.dport  <= n_tok.dport;
        r_tok.len    <= n_tok.len;
    end

    assign o_tok = r_tok;

endmodule

FILE: hdl/packet_class_flow_byte_counter_unit.sv
// top level: packet classifier, class counters and the chain of flow table cells
//
//  channel | signals                       | direction
//  input   | i_valid, o_ready, i_* fields  | header in
//  output  | o_valid, i_ready, o_* fields  | result out
//
// an untracked packet's result is presented in the cycle after accept; a tracked TCP packet
// waits for the token walking the cell chain one slot a cycle.
// one transaction is in flight at a time; o_ready is low until the result is taken.
// synchronous active-low reset empties the table and clears the class counters.
// a stalled result holds in the output register until i_ready.
module packet_class_flow_byte_counter_unit #(
    parameter int TABLE_ENTRIES   = pcfbc_pkg::TABLE_ENTRIES_DEF,
    parameter int BYTE_COUNT_BITS = pcfbc_pkg::BYTE_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [7:0]  i_tcp_flag_bits,
    input  logic [31:0] i_source_addr,
    input  logic [31:0] i_dest_addr,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_frame_len,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_class_code,
    output logic [31:0] o_class_total,
    output logic [1:0]  o_flow_status,
    output logic [6:0]  o_flow_slot,
    output logic [47:0] o_flow_bytes
);
    import pcfbc_pkg::*;

    t_state                  r_state, n_state;
    logic [COUNT_W-1:0]      r_cnt [NUM_CLASSES];
    t_class                  r_cls;
    logic [COUNT_W-1:0]      r_total;
    t_flow_status            r_status, n_status;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [BYTES_OUT_W-1:0]  r_bytes, n_bytes;
    t_token                  r_launch, n_launch;

    t_token                  chain [TABLE_ENTRIES+1];
    t_class                  cls;
    logic                    accept;
    logic [COUNT_W-1:0]      cnt_next;
    t_token                  tail;

    assign accept = i_valid && o_ready;
    assign cls    = classify(i_ether_type, i_ip_proto);
    assign cnt_next = (r_cnt[cls] == {COUNT_W{1'b1}}) ? r_cnt[cls] : r_cnt[cls] + 1'b1;
    assign chain[0] = r_launch;
    assign tail     = chain[TABLE_ENTRIES];

    // cell chain
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        pcfbc_cell #(
            .CELL_INDEX      (g),
            .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    // next state, token launch and result capture
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_slot   = r_slot;
        n_bytes  = r_bytes;
        n_launch = r_launch;
        n_launch.valid = 1'b0;
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready  = 1'b1;
                n_status = FS_UNTRACKED;
                n_slot   = '0;
                n_bytes  = '0;
                if (i_valid) begin
                    if (cls == CLS_TCP && flags_tracked(i_tcp_flag_bits)) begin
                        n_launch.valid  = 1'b1;
                        n_launch.done   = 1'b0;
                        n_launch.status = FS_FULL;
                        n_launch.slot   = '0;
                        n_launch.bytes  = '0;
                        n_launch.saddr  = i_source_addr;
                        n_launch.daddr  = i_dest_addr;
                        n_launch.sport  = i_source_port;
                        n_launch.dport  = i_dest_port;
                        n_launch.len    = i_frame_len;
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_SEND;
                    end
                end
            end
            ST_WALK: begin
                if (tail.valid) begin
                    n_status = tail.status;
                    n_slot   = tail.slot;
                    n_bytes  = tail.bytes;
                    n_state  = ST_SEND;
                end
            end
            ST_SEND: begin
                o_valid = 1'b1;
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_launch.valid <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) r_cnt[k] <= '0;
        end else begin
            r_state        <= n_state;
            r_launch.valid <= n_launch.valid;
            if (accept) r_cnt[cls] <= cnt_next;
        end
        r_launch.done   <= n_launch.done;
        r_launch.status <= n_launch.status;
        r_launch.slot   <= n_launch.slot;
        r_launch.bytes  <= n_launch.bytes;
        r_launch.saddr  <= n_launch.saddr;
        r_launch.daddr  <= n_launch.daddr;
        r_launch.sport  <= n_launch.sport;
        r_launch.dport  <= n_launch.dport;
        r_launch.len    <= n_launch.len;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_bytes  <= n_bytes;
        if (accept) begin
            r_cls   <= cls;
            r_total <= cnt_next;
        end
    end

    assign o_class_code  = r_cls;
    assign o_class_total = r_total;
    assign o_flow_status = r_status;
    assign o_flow_slot   = r_slot;
    assign o_flow_bytes  = r_bytes;

`ifndef NO_ASSERTIONS
    // a token leaves the chain only while a lookup is pending
    a_tail_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.valid |-> r_state == ST_WALK)
        else $error("token left chain outside walk");

    // untracked or full results carry no slot and no bytes
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_flow_status == FS_UNTRACKED || o_flow_status == FS_FULL))
            |-> (o_flow_slot == '0 && o_flow_bytes == '0))
        else $error("slot or bytes set for untracked or full flow");

    // a tracked status only comes with a TCP class
    a_tcp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flow_status != FS_UNTRACKED) |-> o_class_code == CLS_TCP)
        else $error("flow status on non-tcp packet");

    // a launch always follows an accepted transaction
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.valid |-> $past(accept))
        else $error("token launched without a transaction");
`endif

endmodule
